>>> hw/rtl/qnl_pkg.sv
`timescale 1ns / 1ps
// qnl_pkg: widths, constants, stage layout and seed table for the nlerp pipeline.
// No dependencies.
package qnl_pkg;

   localparam int CW           = 16;           // component width, Q2.(CW-2)
   localparam int FRAC         = CW - 2;
   localparam int NEWTON_STEPS = 2;

   localparam logic [15:0] BLEND_ONE = 16'h8000;

   localparam int AB_W   = 2 * CW;             // a*b product
   localparam int DOT_W  = 2 * CW + 2;         // sum of four products
   localparam int PA_W   = CW + 17;            // weight * component
   localparam int PSUM_W = CW + 18;            // blended component
   localparam int MAG_W  = CW + 16;            // |blended component|
   localparam int POS_W  = $clog2(MAG_W);
   localparam int NORM   = 28;                 // normalized max in [2^28, 2^29)

   localparam logic [31:0] Q30_THREE = 32'hC000_0000;

   // final rounding shift: q + 58 - FRAC
   localparam int SH_LO = 58 - FRAC;
   localparam int SH_HI = 59 - FRAC;

   // pipeline layout
   localparam int ST_SHIFT  = 3;
   localparam int ST_SQ     = 4;
   localparam int ST_SUM    = 5;
   localparam int ST_SEED   = 6;
   localparam int ST_NEWTON = 7;
   localparam int ST_FINAL  = ST_NEWTON + 3 * NEWTON_STEPS;
   localparam int NST       = ST_FINAL + 1;

   typedef struct packed {
      logic [3:0][28:0] mag;
      logic [3:0]       neg;
      logic [3:0][59:0] wide;   // squares, later final products
      logic             q;
      logic             zero;
      logic [31:0]      xq;
      logic [31:0]      y;
      logic [31:0]      aux;    // y^2, then x*y^2
   } carry_type;

   // 65536 / sqrt(i + 0.5) for i = 4..15, Q1.15
   function automatic logic [15:0] seed_lookup(input logic [3:0] idx);
      logic [15:0] r;
      case (idx)
         4'd4:    r = 16'd30894;
         4'd5:    r = 16'd27945;
         4'd6:    r = 16'd25705;
         4'd7:    r = 16'd23930;
         4'd8:    r = 16'd22479;
         4'd9:    r = 16'd21263;
         4'd10:   r = 16'd20225;
         4'd11:   r = 16'd19325;
         4'd12:   r = 16'd18536;
         4'd13:   r = 16'd17837;
         4'd14:   r = 16'd17211;
         4'd15:   r = 16'd16646;
         default: r = 16'd30894;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/quaternion_nlerp_unit.sv
`timescale 1ns / 1ps
// quaternion_nlerp_unit: pipelined normalized lerp of two Q2.14 quaternions.
// Depends on qnl_pkg.
// One transaction per cycle sustained while rsp_ready is held high.
// Rate is set by the stage chain: each Newton step takes three stages, one per
//   32x32 multiply; a stalled response holds only the stages behind it, bubbles
//   collapse so req_ready stays high while any stage is free.
// Reset: synchronous, active high; clears all stage valid bits, payload is not reset.
module quaternion_nlerp_unit
   import qnl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [CW-1:0] req_first_x,
   input  logic signed [CW-1:0] req_first_y,
   input  logic signed [CW-1:0] req_first_z,
   input  logic signed [CW-1:0] req_first_w,
   input  logic signed [CW-1:0] req_second_x,
   input  logic signed [CW-1:0] req_second_y,
   input  logic signed [CW-1:0] req_second_z,
   input  logic signed [CW-1:0] req_second_w,
   input  logic        [15:0]   req_blend,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [CW-1:0] rsp_out_x,
   output logic signed [CW-1:0] rsp_out_y,
   output logic signed [CW-1:0] rsp_out_z,
   output logic signed [CW-1:0] rsp_out_w,
   output logic                 rsp_zero_length
);

   // ---------------------------------------------------------------
   // Stage valid bits and per-stage advance enables.
   // A stage loads when it is empty or the stage after it moves.
   // ---------------------------------------------------------------
   logic [NST-1:0] v_ff;
   logic [NST:0]   en;
   logic           rsp_valid_ff;

   always_comb begin
      en[NST] = !rsp_valid_ff || rsp_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en[0]) v_ff[0] <= req_valid;
         for (int k = 1; k < NST; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
         if (en[NST]) rsp_valid_ff <= v_ff[NST-1];
      end
   end

   // ---------------------------------------------------------------
   // Stage 0: clamp blend, all twelve products.
   // ---------------------------------------------------------------
   logic signed [CW-1:0]   a [4];
   logic signed [CW-1:0]   b [4];
   logic        [15:0]     f_cl;
   logic        [15:0]     inv;
   logic signed [AB_W-1:0] ab_in [4];
   logic signed [PA_W-1:0] pa_in [4];
   logic signed [PA_W-1:0] pb_in [4];
   logic signed [AB_W-1:0] ab_ff [4];
   logic signed [PA_W-1:0] pa_ff [4];
   logic signed [PA_W-1:0] pb_ff [4];

   assign a[0] = req_first_x;
   assign a[1] = req_first_y;
   assign a[2] = req_first_z;
   assign a[3] = req_first_w;
   assign b[0] = req_second_x;
   assign b[1] = req_second_y;
   assign b[2] = req_second_z;
   assign b[3] = req_second_w;

   always_comb begin
      f_cl = (req_blend > BLEND_ONE) ? BLEND_ONE : req_blend;
      inv  = BLEND_ONE - f_cl;
      for (int i = 0; i < 4; i++) begin
         ab_in[i] = AB_W'(a[i]) * AB_W'(b[i]);
         pa_in[i] = PA_W'($signed({1'b0, inv}))  * PA_W'(a[i]);
         pb_in[i] = PA_W'($signed({1'b0, f_cl})) * PA_W'(b[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ab_ff <= ab_in;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: dot sign picks the short arc, blend, sign/magnitude.
   // A zero dot product keeps the positive weight.
   // ---------------------------------------------------------------
   logic signed [DOT_W-1:0]  dot;
   logic signed [PSUM_W-1:0] p [4];
   logic        [PSUM_W-1:0] p_abs [4];
   logic        [MAG_W-1:0]  mag1_in [4];
   logic        [3:0]        neg1_in;
   logic        [MAG_W-1:0]  mag1_ff [4];
   logic        [3:0]        neg1_ff;

   always_comb begin
      dot = '0;
      for (int i = 0; i < 4; i++) dot = dot + DOT_W'(ab_ff[i]);
      for (int i = 0; i < 4; i++) begin
         p[i] = dot[DOT_W-1] ? (PSUM_W'(pa_ff[i]) - PSUM_W'(pb_ff[i]))
                             : (PSUM_W'(pa_ff[i]) + PSUM_W'(pb_ff[i]));
         neg1_in[i] = p[i][PSUM_W-1];
         p_abs[i]   = neg1_in[i] ? PSUM_W'(-p[i]) : PSUM_W'(p[i]);
         mag1_in[i] = p_abs[i][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         mag1_ff <= mag1_in;
         neg1_ff <= neg1_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: leading one of the largest magnitude (OR of all four
   // has the same leading one).
   // ---------------------------------------------------------------
   logic [MAG_W-1:0] orv;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] pos_ff;
   logic             zero2_ff;
   logic [MAG_W-1:0] mag2_ff [4];
   logic [3:0]       neg2_ff;

   always_comb begin
      orv    = mag1_ff[0] | mag1_ff[1] | mag1_ff[2] | mag1_ff[3];
      pos_in = '0;
      for (int j = 0; j < MAG_W; j++) begin
         if (orv[j]) pos_in = POS_W'(j);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         pos_ff   <= pos_in;
         zero2_ff <= (orv == '0);
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
      end
   end

   // ---------------------------------------------------------------
   // Carry pipeline from stage 3 on.
   // ---------------------------------------------------------------
   carry_type c_in [ST_SHIFT:NST-1];
   carry_type c_ff [ST_SHIFT:NST-1];

   always_ff @(posedge clock) begin
      for (int k = ST_SHIFT; k < NST; k++) begin
         if (en[k]) c_ff[k] <= c_in[k];
      end
   end

   // Stage 3: scale so the max lands in [2^28, 2^29); right shifts truncate.
   always_comb begin
      logic [MAG_W+NORM-1:0] sh;
      c_in[ST_SHIFT]      = '0;
      c_in[ST_SHIFT].neg  = neg2_ff;
      c_in[ST_SHIFT].zero = zero2_ff;
      for (int i = 0; i < 4; i++) begin
         sh = {mag2_ff[i], {NORM{1'b0}}} >> pos_ff;
         c_in[ST_SHIFT].mag[i] = sh[28:0];
      end
   end

   // Stage 4: squares.
   always_comb begin
      c_in[ST_SQ] = c_ff[ST_SHIFT];
      for (int i = 0; i < 4; i++) begin
         c_in[ST_SQ].wide[i] = 60'(c_ff[ST_SHIFT].mag[i]) * 60'(c_ff[ST_SHIFT].mag[i]);
      end
   end

   // Stage 5: sum of squares, pick q, x in Q2.30.
   always_comb begin
      logic [59:0] s_sum;
      s_sum = c_ff[ST_SQ].wide[0] + c_ff[ST_SQ].wide[1]
            + c_ff[ST_SQ].wide[2] + c_ff[ST_SQ].wide[3];
      c_in[ST_SUM]    = c_ff[ST_SQ];
      c_in[ST_SUM].q  = |s_sum[59:58];
      c_in[ST_SUM].xq = c_in[ST_SUM].q ? s_sum[59:28] : s_sum[57:26];
   end

   // Stage 6: table seed.
   always_comb begin
      logic [3:0] idx;
      idx = c_ff[ST_SUM].xq[31:28];
      if (idx < 4'd4) idx = 4'd4;
      c_in[ST_SEED]   = c_ff[ST_SUM];
      c_in[ST_SEED].y = 32'(seed_lookup(idx)) << 15;
   end

   // Newton steps, three stages each: y^2, x*y^2, y*(3 - t)/2.
   for (genvar g = 0; g < NEWTON_STEPS; g++) begin : g_newton
      localparam int B = ST_NEWTON + 3 * g;

      always_comb begin
         logic [63:0] pr;
         pr          = 64'(c_ff[B-1].y) * 64'(c_ff[B-1].y);
         c_in[B]     = c_ff[B-1];
         c_in[B].aux = pr[61:30];
      end

      always_comb begin
         logic [63:0] pr;
         pr            = 64'(c_ff[B].xq) * 64'(c_ff[B].aux);
         c_in[B+1]     = c_ff[B];
         c_in[B+1].aux = pr[61:30];
      end

      always_comb begin
         logic [63:0] pr;
         pr          = 64'(c_ff[B+1].y) * 64'(Q30_THREE - c_ff[B+1].aux);
         c_in[B+2]   = c_ff[B+1];
         c_in[B+2].y = (c_ff[B+1].aux >= Q30_THREE) ? 32'd0 : pr[62:31];
      end
   end

   // Final multiply: magnitude times inverse length.
   always_comb begin
      c_in[ST_FINAL] = c_ff[ST_FINAL-1];
      for (int i = 0; i < 4; i++) begin
         c_in[ST_FINAL].wide[i] = 60'(c_ff[ST_FINAL-1].mag[i]) * 60'(c_ff[ST_FINAL-1].y);
      end
   end

   // ---------------------------------------------------------------
   // Output register: round half away from zero, saturate to one,
   // apply sign. Zero-length blends come out as zero with the flag.
   // ---------------------------------------------------------------
   logic signed [CW-1:0] out_in [4];
   logic signed [CW-1:0] out_ff [4];
   logic                 zero_ff;

   always_comb begin
      logic [60:0]   rnd;
      logic [60:0]   r;
      logic [CW-1:0] rv;
      int unsigned   sh;
      sh = c_ff[ST_FINAL].q ? SH_HI : SH_LO;
      for (int i = 0; i < 4; i++) begin
         rnd = 61'(c_ff[ST_FINAL].wide[i]) + (61'(1) << (sh - 1));
         r   = rnd >> sh;
         if (r > 61'(1) << FRAC) r = 61'(1) << FRAC;
         rv  = r[CW-1:0];
         if (c_ff[ST_FINAL].zero)        out_in[i] = '0;
         else if (c_ff[ST_FINAL].neg[i]) out_in[i] = $signed(CW'(-rv));
         else                            out_in[i] = $signed(rv);
      end
   end

   always_ff @(posedge clock) begin
      if (en[NST]) begin
         out_ff  <= out_in;
         zero_ff <= c_ff[ST_FINAL].zero;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = out_ff[0];
   assign rsp_out_y       = out_ff[1];
   assign rsp_out_z       = out_ff[2];
   assign rsp_out_w       = out_ff[3];
   assign rsp_zero_length = zero_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   localparam logic signed [CW-1:0] ONE_Q  = CW'(1) << FRAC;
   localparam logic signed [CW-1:0] MONE_Q = -(CW'(1) << FRAC);

   // flagged transactions carry an all-zero quaternion
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |->
         rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0 && rsp_out_w == '0)
      else $error("zero-length transaction with nonzero components");

   // saturation keeps every component within plus or minus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_out_x <= ONE_Q && rsp_out_x >= MONE_Q &&
         rsp_out_y <= ONE_Q && rsp_out_y >= MONE_Q &&
         rsp_out_z <= ONE_Q && rsp_out_z >= MONE_Q &&
         rsp_out_w <= ONE_Q && rsp_out_w >= MONE_Q)
      else $error("component outside unit range");

   // an empty output register never backs up the input side
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while output register empty");

   // a response taken with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !v_ff[NST-1] |=> !rsp_valid)
      else $error("response repeated after handoff");

endmodule
